// ----- sv/hpr_pkg.sv -----
`timescale 1ns / 1ps

package hpr_pkg;

  // Field widths of the request and result transactions.
  localparam int REQ_W    = 2;
  localparam int COL_W    = 11;
  localparam int TAP_W    = 3;
  localparam int PIX_W    = 16;
  localparam int COEF_W   = 16;
  localparam int TCNT_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Default sizes of the stores.
  localparam int LINE_MAX_DEF = 2048;
  localparam int OUT_MAX_DEF  = 2048;
  localparam int TAPS_MAX_DEF = 8;

  // Fixed-point constants.
  localparam int ROUND_HALF = 1 << 13;
  localparam int FRAC_BITS  = 14;
  localparam int PIX_OFFSET = 32768;

  // Register reset values.
  localparam logic [PIX_W-1:0]  WHITE_LEVEL_RST = 16'hFFFF;
  localparam logic [TCNT_W-1:0] TAP_COUNT_RST   = 4'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_COEFF   = 2'd0,
    REQ_LEFT    = 2'd1,
    REQ_PIXEL   = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEFT,
    ST_ISSUE,
    ST_DRAIN,
    ST_ROUND,
    ST_DONE
  } state_t;

endpackage

// ----- sv/hpr_in_if.sv -----
`timescale 1ns / 1ps

interface hpr_in_if;
  logic                                valid;
  logic                                ready;
  logic [hpr_pkg::REQ_W-1:0]           req_type;
  logic [hpr_pkg::COL_W-1:0]           out_index;
  logic [hpr_pkg::TAP_W-1:0]           tap_index;
  logic [hpr_pkg::COL_W-1:0]           src_position;
  logic signed [hpr_pkg::COEF_W-1:0]   coeff_value;
  logic [hpr_pkg::COL_W-1:0]           left_value;
  logic [hpr_pkg::PIX_W-1:0]           pixel_value;

  modport source (
    output valid, req_type, out_index, tap_index, src_position,
           coeff_value, left_value, pixel_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, out_index, tap_index, src_position,
           coeff_value, left_value, pixel_value,
    output ready
  );
endinterface

// ----- sv/hpr_out_if.sv -----
`timescale 1ns / 1ps

interface hpr_out_if;
  logic                      valid;
  logic                      ready;
  logic [hpr_pkg::PIX_W-1:0] out_pixel;
  logic [hpr_pkg::COL_W-1:0] out_column;
  logic                      range_error;

  modport source (
    output valid, out_pixel, out_column, range_error,
    input  ready
  );

  modport sink (
    input  valid, out_pixel, out_column, range_error,
    output ready
  );
endinterface

// ----- sv/horizontal_polyphase_resampler.sv -----
`timescale 1ns / 1ps

// Horizontal polyphase resampler for 16-bit pixels.
// Requests arrive on in_ch. Coefficient, left-offset and pixel writes each
// take one transaction and produce no result. A compute
// request for an output column produces one transaction on out_ch carrying
// the filtered pixel, its column and a flag for taps beyond the line store.
// Requests addressing columns or taps outside the stores are dropped.
// A compute request occupies the block (taps clamped to 1..TAPS_MAX) in
// steps: the left offset is fetched, then one multiply-accumulate per tap
// is issued through the coefficient and line memory read ports, the
// pipeline drains, the sum is rounded, and the output register is loaded.
// The output register holds a finished result while the receiver stalls; a
// new request is still taken meanwhile, and the load of the next result
// waits, with in_ch not ready, until out_ch.ready frees the register.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle,
// empties the output register, clears the accumulator and restores the
// white level to 65535 and tap_count to 4. Memory contents are not cleared
// and read as undefined until written. Configuration writes on cfg_we are
// taken at any edge and should only be made while the block is idle.

module horizontal_polyphase_resampler #(
  parameter int LINE_MAX = hpr_pkg::LINE_MAX_DEF,
  parameter int OUT_MAX  = hpr_pkg::OUT_MAX_DEF,
  parameter int TAPS_MAX = hpr_pkg::TAPS_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  hpr_in_if.sink                             in_ch,
  hpr_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [hpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hpr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Each output column owns TAPS_MAX coefficient entries followed by one
  // entry holding its left offset, so two memories hold all the tables.
  localparam int ROW_LEN    = TAPS_MAX + 1;
  localparam int COEF_DEPTH = OUT_MAX * ROW_LEN;
  localparam int CAW        = $clog2(COEF_DEPTH);
  localparam int LAW        = $clog2(LINE_MAX);
  localparam int KW         = (TAPS_MAX > 1) ? $clog2(TAPS_MAX) : 1;
  localparam int TE_W       = 6;
  localparam int SCOL_W     = 12;
  localparam int PROD_W     = 2 * hpr_pkg::COEF_W;
  localparam int ACC_W      = PROD_W + 1 + $clog2(TAPS_MAX);
  localparam int RND_W      = ACC_W - hpr_pkg::FRAC_BITS;

  // Configuration registers.
  logic [hpr_pkg::PIX_W-1:0]  white_level_r;
  logic [hpr_pkg::TCNT_W-1:0] tap_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_level_r <= hpr_pkg::WHITE_LEVEL_RST;
      tap_count_r   <= hpr_pkg::TAP_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpr_pkg::CFG_WHITE_LEVEL: white_level_r <= cfg_wdata;
        hpr_pkg::CFG_TAP_COUNT:   tap_count_r   <= cfg_wdata[hpr_pkg::TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A tap count of zero acts as one, and counts beyond the table as TAPS_MAX.
  logic [TE_W-1:0] taps_eff;
  always_comb begin
    if (tap_count_r == '0) begin
      taps_eff = TE_W'(1);
    end else if (32'(tap_count_r) > TAPS_MAX) begin
      taps_eff = TE_W'(TAPS_MAX);
    end else begin
      taps_eff = TE_W'(tap_count_r);
    end
  end

  // Sequencer and datapath registers.
  hpr_pkg::state_t state_r, state_nxt;
  logic [CAW-1:0]                 base_r;
  logic [hpr_pkg::COL_W-1:0]      column_r;
  logic [hpr_pkg::COL_W-1:0]      left_r;
  logic [KW-1:0]                  k_r;
  logic                           err_r;
  logic                           s1_vld_r;
  logic                           s1_oob_r;
  logic                           p_vld_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ACC_W-1:0]        mac_sum_r;
  logic signed [RND_W-1:0]        rnd_r;

  logic                           out_valid_r;
  logic [hpr_pkg::PIX_W-1:0]      out_pixel_r;
  logic [hpr_pkg::COL_W-1:0]      out_column_r;
  logic                           range_error_r;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Request decode.
  logic [CAW-1:0]   in_base;
  logic             in_col_ok;
  logic             coef_we, line_we;
  logic [CAW-1:0]   coef_waddr;
  logic [hpr_pkg::COEF_W-1:0] coef_wdata;
  logic             start;

  assign in_base   = CAW'(32'(in_ch.out_index) * ROW_LEN);
  assign in_col_ok = 32'(in_ch.out_index) < OUT_MAX;

  always_comb begin
    coef_we    = 1'b0;
    line_we    = 1'b0;
    coef_waddr = in_base + CAW'(in_ch.tap_index);
    coef_wdata = in_ch.coeff_value;
    start      = 1'b0;
    unique case (in_ch.req_type)
      hpr_pkg::REQ_COEFF: begin
        coef_we = in_fire && in_col_ok && (32'(in_ch.tap_index) < TAPS_MAX);
      end
      hpr_pkg::REQ_LEFT: begin
        coef_we    = in_fire && in_col_ok;
        coef_waddr = in_base + CAW'(TAPS_MAX);
        coef_wdata = hpr_pkg::COEF_W'(in_ch.left_value);
      end
      hpr_pkg::REQ_PIXEL: begin
        line_we = in_fire && (32'(in_ch.src_position) < LINE_MAX);
      end
      hpr_pkg::REQ_COMPUTE: begin
        start = in_fire && in_col_ok;
      end
      default: ;
    endcase
  end

  // Source column of the tap being issued.
  logic [SCOL_W-1:0] src_col;
  logic              src_oob;
  logic              last_tap;
  assign src_col  = SCOL_W'(left_r) + SCOL_W'(k_r);
  assign src_oob  = 32'(src_col) >= LINE_MAX;
  assign last_tap = (32'(k_r) + 1) == 32'(taps_eff);

  // Coefficient read address: the left-offset entry when a compute starts,
  // then one tap per cycle.
  logic [CAW-1:0] coef_raddr;
  assign coef_raddr = (state_r == hpr_pkg::ST_IDLE) ? (in_base + CAW'(TAPS_MAX))
                                                    : (base_r + CAW'(k_r));

  logic out_free;
  logic out_load;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      hpr_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (start) begin
          state_nxt = hpr_pkg::ST_LEFT;
        end
      end
      hpr_pkg::ST_LEFT: begin
        state_nxt = hpr_pkg::ST_ISSUE;
      end
      hpr_pkg::ST_ISSUE: begin
        if (last_tap) begin
          state_nxt = hpr_pkg::ST_DRAIN;
        end
      end
      hpr_pkg::ST_DRAIN: begin
        if (!s1_vld_r && !p_vld_r) begin
          state_nxt = hpr_pkg::ST_ROUND;
        end
      end
      hpr_pkg::ST_ROUND: begin
        state_nxt = hpr_pkg::ST_DONE;
      end
      hpr_pkg::ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = hpr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hpr_pkg::ST_IDLE;
    endcase
  end

  // Coefficient and left-offset memory.
  logic [hpr_pkg::COEF_W-1:0] coef_mem [COEF_DEPTH];
  logic [hpr_pkg::COEF_W-1:0] coef_q;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_q <= coef_mem[coef_raddr];
  end

  // Line store.
  logic [hpr_pkg::PIX_W-1:0] line_mem [LINE_MAX];
  logic [hpr_pkg::PIX_W-1:0] line_q;

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[LAW'(in_ch.src_position)] <= in_ch.pixel_value;
    end
    line_q <= line_mem[LAW'(src_col)];
  end

  // Flipping the top bit of the pixel subtracts the mid-scale offset.
  logic signed [hpr_pkg::PIX_W-1:0] pix_centred;
  assign pix_centred = $signed({~line_q[hpr_pkg::PIX_W-1], line_q[hpr_pkg::PIX_W-2:0]});

  // Signed product of one tap, sign-extended to the full product width.
  logic signed [PROD_W-1:0] prod_full;
  assign prod_full = $signed(coef_q) * pix_centred;

  logic signed [ACC_W-1:0] acc_rnd;
  assign acc_rnd = mac_sum_r + ACC_W'(hpr_pkg::ROUND_HALF);

  logic signed [RND_W:0] res_off;
  assign res_off = (RND_W + 1)'(rnd_r) + (RND_W + 1)'(hpr_pkg::PIX_OFFSET);

  logic [hpr_pkg::PIX_W-1:0] res_clamped;
  always_comb begin
    if (res_off > $signed((RND_W + 1)'(white_level_r))) begin
      res_clamped = white_level_r;
    end else if (res_off < 0) begin
      res_clamped = '0;
    end else begin
      res_clamped = hpr_pkg::PIX_W'(res_off);
    end
  end

  // Control state of the multiply-accumulate pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      err_r     <= 1'b0;
      s1_vld_r  <= 1'b0;
      p_vld_r   <= 1'b0;
      mac_sum_r <= '0;
    end else begin
      s1_vld_r <= (state_r == hpr_pkg::ST_ISSUE);
      p_vld_r  <= s1_vld_r;
      if (start) begin
        k_r       <= '0;
        err_r     <= 1'b0;
        mac_sum_r <= '0;
      end else begin
        if (state_r == hpr_pkg::ST_ISSUE) begin
          k_r <= k_r + KW'(1);
          if (src_oob) begin
            err_r <= 1'b1;
          end
        end
        if (p_vld_r) begin
          mac_sum_r <= mac_sum_r + ACC_W'(prod_r);
        end
      end
    end
  end

  // Payload registers of the pipeline.
  always_ff @(posedge clk) begin
    if (start) begin
      base_r   <= in_base;
      column_r <= in_ch.out_index;
    end
    if (state_r == hpr_pkg::ST_LEFT) begin
      left_r <= coef_q[hpr_pkg::COL_W-1:0];
    end
    s1_oob_r <= src_oob;
    prod_r   <= s1_oob_r ? '0 : prod_full;
    rnd_r    <= $signed(acc_rnd[ACC_W-1:hpr_pkg::FRAC_BITS]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_r   <= res_clamped;
      out_column_r  <= column_r;
      range_error_r <= err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_pixel   = out_pixel_r;
  assign out_ch.out_column  = out_column_r;
  assign out_ch.range_error = range_error_r;

  // A result is only loaded once every product has reached the accumulator.
  a_drained_at_done: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == hpr_pkg::ST_DONE) |-> (!s1_vld_r && !p_vld_r)
  ) else $error("result loaded before the accumulator pipeline drained");

  // An accepted in-range compute request always starts the offset fetch.
  a_compute_starts: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.req_type == hpr_pkg::REQ_COMPUTE) && in_col_ok)
      |=> (state_r == hpr_pkg::ST_LEFT)
  ) else $error("compute request did not start the sequencer");

  // The tap counter stays within the coefficient row while issuing.
  a_tap_in_row: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == hpr_pkg::ST_ISSUE) |-> (32'(k_r) < TAPS_MAX)
  ) else $error("tap counter ran past the coefficient row");

  // A new result appears only out of the final sequencer state.
  a_result_from_done: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == hpr_pkg::ST_DONE)
  ) else $error("output became valid outside the done state");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the horizontal polyphase resampler.
module tb;

  localparam int LINE_LEN        = hpr_pkg::LINE_MAX_DEF;
  localparam int OUT_COLS        = hpr_pkg::OUT_MAX_DEF;
  localparam int TAP_SLOTS       = hpr_pkg::TAPS_MAX_DEF;
  localparam int CIDX_W          = $clog2(OUT_COLS * TAP_SLOTS);
  localparam int LIDX_W          = $clog2(LINE_LEN);
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 290;
  localparam int HOLD_OFF_CYCLES = 300;
  // Allow twice the time for which the longest compute occupies the block.
  localparam int SETTLE_CYCLES   = 2 * (hpr_pkg::TAPS_MAX_DEF + 6);
  localparam int CYCLE_LIMIT     = 500000;

  // One request transaction as it is offered on in_ch.
  typedef struct packed {
    hpr_pkg::req_t                     kind;
    logic [hpr_pkg::COL_W-1:0]         out_index;
    logic [hpr_pkg::TAP_W-1:0]         tap;
    logic [hpr_pkg::COL_W-1:0]         src;
    logic signed [hpr_pkg::COEF_W-1:0] coeff;
    logic [hpr_pkg::COL_W-1:0]         left;
    logic [hpr_pkg::PIX_W-1:0]         pixel;
  } request_t;

  // One result transaction as it leaves on out_ch.
  typedef struct packed {
    logic [hpr_pkg::PIX_W-1:0] pixel;
    logic [hpr_pkg::COL_W-1:0] column;
    logic                      range_err;
  } result_t;

  // The scoreboard mirrors the three stores and both registers. Every accepted
  // write updates the mirror; a compute request instead predicts its filtered
  // pixel, which is queued until the matching result transaction turns up.
  class resample_scoreboard;
    logic [hpr_pkg::PIX_W-1:0]         line_mem [LINE_LEN];
    logic signed [hpr_pkg::COEF_W-1:0] coeff_mem [OUT_COLS*TAP_SLOTS];
    logic [hpr_pkg::COL_W-1:0]         left_mem [OUT_COLS];
    logic [hpr_pkg::PIX_W-1:0]         white_level;
    logic [hpr_pkg::TCNT_W-1:0]        tap_count;
    result_t                           expected_pixels[$];
    int failures, n_coeff, n_left, n_pixel, n_compute;
    int n_range, n_clamp_hi, n_clamp_lo;

    function new();
      white_level = hpr_pkg::WHITE_LEVEL_RST;
      tap_count   = hpr_pkg::TAP_COUNT_RST;
    endfunction

    function void write_register(logic [hpr_pkg::CFG_IDX_W-1:0] idx,
                                 logic [hpr_pkg::CFG_DATA_W-1:0] data);
      if (idx == hpr_pkg::CFG_WHITE_LEVEL) begin
        white_level = data[hpr_pkg::PIX_W-1:0];
      end else if (idx == hpr_pkg::CFG_TAP_COUNT) begin
        tap_count = data[hpr_pkg::TCNT_W-1:0];
      end
    endfunction

    function void take_request(request_t r);
      int      taps;
      int      col;
      int      k;
      longint  acc;
      longint  rounded;
      bit      err;
      result_t res;
      case (r.kind)
        hpr_pkg::REQ_COEFF: begin
          coeff_mem[CIDX_W'(r.out_index * TAP_SLOTS + r.tap)] = r.coeff;
          n_coeff++;
        end
        hpr_pkg::REQ_LEFT: begin
          left_mem[r.out_index] = r.left;
          n_left++;
        end
        hpr_pkg::REQ_PIXEL: begin
          line_mem[r.src] = r.pixel;
          n_pixel++;
        end
        default: begin
          // A tap count of zero behaves as one, anything above the slot count as the maximum.
          taps = (tap_count == 0) ? 1 :
                 ((int'(tap_count) > TAP_SLOTS) ? TAP_SLOTS : int'(tap_count));
          acc  = 0;
          err  = 1'b0;
          for (k = 0; k < taps; k++) begin
            col = int'(left_mem[r.out_index]) + k;
            if (col >= LINE_LEN) begin
              // Taps past the end of the line add nothing but raise the flag.
              err = 1'b1;
            end else begin
              acc += longint'(coeff_mem[CIDX_W'(r.out_index * TAP_SLOTS + k)]) *
                     (longint'(line_mem[LIDX_W'(col)]) - hpr_pkg::PIX_OFFSET);
            end
          end
          rounded = ((acc + hpr_pkg::ROUND_HALF) >>> hpr_pkg::FRAC_BITS) +
                    hpr_pkg::PIX_OFFSET;
          if (rounded > longint'(white_level)) begin
            rounded = longint'(white_level);
            n_clamp_hi++;
          end
          if (rounded < 0) begin
            rounded = 0;
            n_clamp_lo++;
          end
          res.pixel     = rounded[hpr_pkg::PIX_W-1:0];
          res.column    = r.out_index;
          res.range_err = err;
          n_range      += int'(err);
          n_compute++;
          expected_pixels.push_back(res);
        end
      endcase
    endfunction

    function void check_pixel(result_t got);
      result_t want;
      if (expected_pixels.size() == 0) begin
        failures++;
        $error("unexpected result: column %0d, pixel %0d", got.column, got.pixel);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel !== want.pixel) begin
        failures++;
        $error("out_pixel mismatch: expected %0d, got %0d", want.pixel, got.pixel);
      end
      if (got.column !== want.column) begin
        failures++;
        $error("out_column mismatch: expected %0d, got %0d", want.column, got.column);
      end
      if (got.range_err !== want.range_err) begin
        failures++;
        $error("range_error mismatch: expected %0d, got %0d", want.range_err, got.range_err);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [hpr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hpr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  hpr_in_if  in_ch ();
  hpr_out_if out_ch ();

  horizontal_polyphase_resampler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  resample_scoreboard sb;

  // What the stimulus knows it has written. A compute request is only issued
  // for a column whose offset, coefficients and source pixels are all
  // defined, since reading an unwritten entry is outside the contract.
  bit                        coeff_set [OUT_COLS*TAP_SLOTS];
  bit                        line_set [LINE_LEN];
  bit                        left_set [OUT_COLS];
  logic [hpr_pkg::COL_W-1:0] left_of [OUT_COLS];
  int                        taps_now = hpr_pkg::TAP_COUNT_RST;

  bit tx_calm;        // sender offers back to back when set
  bit rx_calm;        // receiver never stalls when set
  int hold_request;   // cycles for which the receiver should hold off once
  int items_sent;
  int cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver. Before every transaction it waits a random number of cycles
  // (none in a calm phase), or the long hold-off when one has been asked for.
  // The result is sampled at the edge that completes the handshake.
  initial begin : receiver
    int stall;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = rx_calm ? 0 : int'($urandom_range(0, 5));
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_pixel('{out_ch.out_pixel, out_ch.out_column, out_ch.range_error});
    end
  end

  // Offers one request after a random gap and returns at the edge where it is
  // accepted. The caller's next assignment to valid lands in that same step,
  // so back-to-back transactions keep valid high throughout.
  task automatic send_request(request_t r);
    int gap;
    gap = tx_calm ? 0 : int'($urandom_range(0, 5));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= r.kind;
    in_ch.out_index    <= r.out_index;
    in_ch.tap_index    <= r.tap;
    in_ch.src_position <= r.src;
    in_ch.coeff_value  <= r.coeff;
    in_ch.left_value   <= r.left;
    in_ch.pixel_value  <= r.pixel;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_request(r);
    case (r.kind)
      hpr_pkg::REQ_COEFF: coeff_set[CIDX_W'(r.out_index * TAP_SLOTS + r.tap)] = 1'b1;
      hpr_pkg::REQ_LEFT: begin
        left_set[r.out_index] = 1'b1;
        left_of[r.out_index]  = r.left;
      end
      hpr_pkg::REQ_PIXEL: line_set[r.src] = 1'b1;
      default: ;
    endcase
    items_sent++;
  endtask

  // Drops valid, waits for every predicted result, then lets the block run dry.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are written on consecutive edges with the enable held high.
  task automatic write_config(int pix_max, int taps);
    cfg_we    <= 1'b1;
    cfg_index <= hpr_pkg::CFG_WHITE_LEVEL;
    cfg_wdata <= pix_max[hpr_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= hpr_pkg::CFG_TAP_COUNT;
    cfg_wdata <= hpr_pkg::CFG_DATA_W'(taps[hpr_pkg::TCNT_W-1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_register(hpr_pkg::CFG_WHITE_LEVEL, pix_max[hpr_pkg::CFG_DATA_W-1:0]);
    sb.write_register(hpr_pkg::CFG_TAP_COUNT,
                      hpr_pkg::CFG_DATA_W'(taps[hpr_pkg::TCNT_W-1:0]));
    taps_now = (taps[hpr_pkg::TCNT_W-1:0] == 0) ? 1 :
               ((int'(taps[hpr_pkg::TCNT_W-1:0]) > TAP_SLOTS) ? TAP_SLOTS :
                int'(taps[hpr_pkg::TCNT_W-1:0]));
  endtask

  // Every field random, including the ones the request kind does not use.
  function automatic request_t any_request();
    request_t r;
    r.kind      = hpr_pkg::req_t'($urandom_range(0, 3));
    r.out_index = hpr_pkg::COL_W'($urandom_range(0, OUT_COLS - 1));
    r.tap       = hpr_pkg::TAP_W'($urandom_range(0, TAP_SLOTS - 1));
    r.src       = hpr_pkg::COL_W'($urandom_range(0, LINE_LEN - 1));
    r.coeff     = hpr_pkg::COEF_W'($urandom_range(0, 65535));
    r.left      = hpr_pkg::COL_W'($urandom_range(0, LINE_LEN - 1));
    r.pixel     = hpr_pkg::PIX_W'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic request_t make_request(hpr_pkg::req_t kind, int oi, int tap, int src,
                                            int coeff, int lv, int pix);
    request_t r;
    r           = any_request();
    r.kind      = kind;
    r.out_index = hpr_pkg::COL_W'(oi);
    r.tap       = hpr_pkg::TAP_W'(tap);
    r.src       = hpr_pkg::COL_W'(src);
    r.coeff     = hpr_pkg::COEF_W'(coeff);
    r.left      = hpr_pkg::COL_W'(lv);
    r.pixel     = hpr_pkg::PIX_W'(pix);
    return r;
  endfunction

  // Mostly filter-like weights so that outputs land mid-range, with some
  // wild values and the two extremes so that both clamps are exercised.
  function automatic logic signed [hpr_pkg::COEF_W-1:0] pick_coeff();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return hpr_pkg::COEF_W'($urandom_range(0, 8192));
    if (sel < 7) return hpr_pkg::COEF_W'(int'($urandom_range(0, 4095)) - 2048);
    if (sel < 9) return hpr_pkg::COEF_W'($urandom_range(0, 65535));
    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  function automatic bit column_ready(logic [hpr_pkg::COL_W-1:0] oi);
    int k;
    int col;
    if (!left_set[oi]) return 1'b0;
    for (k = 0; k < taps_now; k++) begin
      if (!coeff_set[CIDX_W'(oi * TAP_SLOTS + k)]) return 1'b0;
      col = int'(left_of[oi]) + k;
      if (col < LINE_LEN && !line_set[LIDX_W'(col)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // A well-formed burst for one output column: offset, the missing (and some
  // refreshed) coefficients and source pixels, then one or two computes.
  // Columns are drawn mostly from a small pool so that the stores get reused.
  task automatic column_burst();
    request_t                  r;
    logic [hpr_pkg::COL_W-1:0] oi;
    int                        sel;
    int                        k;
    int                        col;
    sel = $urandom_range(0, 9);
    oi  = (sel < 7) ? hpr_pkg::COL_W'($urandom_range(0, 47)) :
                      hpr_pkg::COL_W'($urandom_range(0, OUT_COLS - 1));
    if (!left_set[oi] || $urandom_range(0, 2) != 0) begin
      r      = any_request();
      r.kind = hpr_pkg::REQ_LEFT;
      r.out_index = oi;
      sel    = $urandom_range(0, 9);
      // Some offsets sit near the end of the line so that taps run past it.
      if (sel < 6)      r.left = hpr_pkg::COL_W'($urandom_range(0, 63));
      else if (sel < 8) r.left = hpr_pkg::COL_W'($urandom_range(LINE_LEN - 12, LINE_LEN - 1));
      else              r.left = hpr_pkg::COL_W'($urandom_range(0, LINE_LEN - 1));
      send_request(r);
    end
    for (k = 0; k < TAP_SLOTS; k++) begin
      if ((k < taps_now && !coeff_set[CIDX_W'(oi * TAP_SLOTS + k)]) ||
          $urandom_range(0, 3) == 0) begin
        r           = any_request();
        r.kind      = hpr_pkg::REQ_COEFF;
        r.out_index = oi;
        r.tap       = hpr_pkg::TAP_W'(k);
        r.coeff     = pick_coeff();
        send_request(r);
      end
    end
    for (k = 0; k < taps_now; k++) begin
      col = int'(left_of[oi]) + k;
      if (col < LINE_LEN && (!line_set[LIDX_W'(col)] || $urandom_range(0, 3) == 0)) begin
        r       = any_request();
        r.kind  = hpr_pkg::REQ_PIXEL;
        r.src   = hpr_pkg::COL_W'(col);
        if ($urandom_range(0, 9) == 0) r.pixel = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        send_request(r);
      end
    end
    r           = any_request();
    r.kind      = hpr_pkg::REQ_COMPUTE;
    r.out_index = oi;
    send_request(r);
    if ($urandom_range(0, 3) == 0) send_request(r);
  endtask

  // A stray request of any kind. A compute on a column that is not fully
  // defined is turned into a pixel write instead.
  task automatic stray_request();
    request_t r;
    r = any_request();
    if (r.kind == hpr_pkg::REQ_COMPUTE && !column_ready(r.out_index)) begin
      r.kind = hpr_pkg::REQ_PIXEL;
    end
    send_request(r);
  endtask

  initial begin : stimulus
    int target;
    int pm;
    int tc;
    sb = new();

    // Every input known from time zero.
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = hpr_pkg::CFG_WHITE_LEVEL;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = hpr_pkg::REQ_COEFF;
    in_ch.out_index    = '0;
    in_ch.tap_index    = '0;
    in_ch.src_position = '0;
    in_ch.coeff_value  = '0;
    in_ch.left_value   = '0;
    in_ch.pixel_value  = '0;
    out_ch.ready       = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset configuration (four taps, full range).
    // Column 0 mixes the most negative and most positive weights with black,
    // white and mid-grey pixels, driving the sum to the top clamp.
    send_request(make_request(hpr_pkg::REQ_LEFT, 0, 0, 0, 0, 0, 0));
    send_request(make_request(hpr_pkg::REQ_COEFF, 0, 0, 0, -32768, 0, 0));
    send_request(make_request(hpr_pkg::REQ_COEFF, 0, 1, 0, 32767, 0, 0));
    send_request(make_request(hpr_pkg::REQ_COEFF, 0, 2, 0, 0, 0, 0));
    send_request(make_request(hpr_pkg::REQ_COEFF, 0, 3, 0, 16384, 0, 0));
    send_request(make_request(hpr_pkg::REQ_PIXEL, 0, 0, 0, 0, 0, 0));
    send_request(make_request(hpr_pkg::REQ_PIXEL, 0, 0, 1, 0, 0, 65535));
    send_request(make_request(hpr_pkg::REQ_PIXEL, 0, 0, 2, 0, 0, 32768));
    send_request(make_request(hpr_pkg::REQ_PIXEL, 0, 0, 3, 0, 0, 12345));
    send_request(make_request(hpr_pkg::REQ_COMPUTE, 0, 0, 0, 0, 0, 0));
    // The last output column, with its final tap one past the end of the line.
    send_request(make_request(hpr_pkg::REQ_LEFT, 2047, 0, 0, 0, 2045, 0));
    send_request(make_request(hpr_pkg::REQ_COEFF, 2047, 0, 0, 32767, 0, 0));
    send_request(make_request(hpr_pkg::REQ_COEFF, 2047, 1, 0, -1, 0, 0));
    send_request(make_request(hpr_pkg::REQ_COEFF, 2047, 2, 0, 8192, 0, 0));
    send_request(make_request(hpr_pkg::REQ_COEFF, 2047, 3, 0, -32768, 0, 0));
    send_request(make_request(hpr_pkg::REQ_PIXEL, 0, 0, 2045, 0, 0, 65535));
    send_request(make_request(hpr_pkg::REQ_PIXEL, 0, 0, 2046, 0, 0, 0));
    send_request(make_request(hpr_pkg::REQ_PIXEL, 0, 0, 2047, 0, 0, 65535));
    send_request(make_request(hpr_pkg::REQ_COMPUTE, 2047, 0, 0, 0, 0, 0));
    // Offset at the very last source column: only the first tap is inside.
    send_request(make_request(hpr_pkg::REQ_LEFT, 2047, 0, 0, 0, 2047, 0));
    send_request(make_request(hpr_pkg::REQ_COMPUTE, 2047, 0, 0, 0, 0, 0));
    // Reweight column 0 so the sum goes far negative and clamps to zero.
    send_request(make_request(hpr_pkg::REQ_COEFF, 0, 0, 0, 32767, 0, 0));
    send_request(make_request(hpr_pkg::REQ_COEFF, 0, 1, 0, -32768, 0, 0));
    send_request(make_request(hpr_pkg::REQ_COMPUTE, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Random phases, each under its own configuration. The fixed settings
    // cover the extremes: eight taps and one tap, a zero tap count that acts
    // as one, an oversized count that acts as eight, and the white level at
    // zero and at full scale.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0:       begin pm = 65535; tc = 8;  end
        1:       begin pm = 255;   tc = 1;  end
        2:       begin pm = 0;     tc = 0;  end
        3:       begin pm = 1023;  tc = 15; end
        4:       begin pm = $urandom_range(256, 65535); tc = $urandom_range(0, 15); end
        default: begin pm = 4095;  tc = 4;  end
      endcase
      write_config(pm, tc);
      tx_calm = (phase % 3 == 1);
      rx_calm = (phase % 3 == 2);
      // In the first phase the receiver stops for a long while so that the
      // output register fills and the block pushes back on in_ch.
      if (phase == 0) hold_request = HOLD_OFF_CYCLES;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) stray_request();
        else column_burst();
      end
      wait_idle();
    end

    $display("Run covered %0d coefficient, %0d offset and %0d pixel writes, %0d computes",
             sb.n_coeff, sb.n_left, sb.n_pixel, sb.n_compute);
    $display("  over %0d settings; %0d past the line end, %0d clamped high, %0d clamped to zero",
             N_PHASES + 1, sb.n_range, sb.n_clamp_hi, sb.n_clamp_lo);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/hpr_pkg.sv
sv/hpr_in_if.sv
sv/hpr_out_if.sv
sv/horizontal_polyphase_resampler.sv
bench/tb.sv
